FILE: rtl/ccr_pkg.sv
// Shared types, constants and helpers of the cubic convolution line resampler.
// No dependencies; every other rtl file imports this package.
package ccr_pkg;

  localparam int MAX_LINE    = 4096;
  localparam int FRAC_BITS   = 16;
  localparam int LEN_W       = 13;
  localparam int PIX_W       = 8;
  localparam int STEP_W      = 21;
  localparam int ACC_W       = FRAC_BITS + LEN_W;
  localparam int MAX_RESULTS = 24;
  localparam int BURST_W     = $clog2(MAX_RESULTS + 1);
  localparam int IDX_W       = LEN_W + 2;
  localparam int WGT_W       = FRAC_BITS + 5;
  localparam int SUM_W       = WGT_W + PIX_W + 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_LENGTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATIO    = 2'd2;

  localparam logic [LEN_W-1:0]  SRC_LEN_RESET = LEN_W'(512);
  localparam logic [LEN_W-1:0]  DST_LEN_RESET = LEN_W'(1000);
  localparam logic [STEP_W-1:0] STEP_RESET    = STEP_W'(33522);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_LINE);
  localparam logic [LEN_W-1:0] MIN_SRC = LEN_W'(4);
  localparam logic [LEN_W-1:0] MIN_DST = LEN_W'(2);

  typedef struct packed {
    logic [LEN_W-1:0]  source_length;
    logic [LEN_W-1:0]  dest_length;
    logic [STEP_W-1:0] step_ratio;
  } cfg_t;

  // One classified source pixel on its way to the back end
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [LEN_W-1:0] count;   // pixels received including this one
    logic             last;    // closes the line
  } item_t;

  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] v,
                                               input logic [LEN_W-1:0] lo);
    logic [LEN_W-1:0] r;
    r = v;
    if (v < lo) r = lo;
    else if (v > MAX_LEN) r = MAX_LEN;
    return r;
  endfunction

endpackage

FILE: rtl/ccr_queue.sv
// Two-entry item queue between front and back end of the resampler.
// Depends on ccr_pkg.
module ccr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ccr_pkg::item_t item_i,
  output logic           full_o,
  output logic           head_valid_o,
  output ccr_pkg::item_t head_o,
  input  logic           pop_i
);
  import ccr_pkg::*;

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o       = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + QCNT_W'(1);
    else if (!do_push && do_pop) cnt_d = cnt_q - QCNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= item_i;
  end

endmodule

FILE: rtl/ccr_front.sv
// Front end: accepts source pixels, counts them and marks the line end.
// Depends on ccr_pkg.
module ccr_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [ccr_pkg::PIX_W-1:0] pixel_in_i,
  input  logic [ccr_pkg::LEN_W-1:0] source_length_i,
  input  logic                      q_full_i,
  output logic                      push_o,
  output ccr_pkg::item_t            push_item_o
);
  import ccr_pkg::*;

  logic [LEN_W-1:0] source_count_q, source_count_d;
  logic [LEN_W-1:0] n_len, cnt_now;
  logic             last_now;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign n_len      = sat_len(source_length_i, MIN_SRC);
  assign cnt_now    = source_count_q + LEN_W'(1);
  assign last_now   = (cnt_now >= n_len);

  assign push_item_o.pixel = pixel_in_i;
  assign push_item_o.count = cnt_now;
  assign push_item_o.last  = last_now;

  always_comb begin
    source_count_d = source_count_q;
    if (push_o) source_count_d = last_now ? '0 : cnt_now;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_count_q <= '0;
    end else begin
      source_count_q <= source_count_d;
    end
  end

endmodule

FILE: rtl/ccr_back.sv
// Back end: tap window, phase accumulator and the per-output cubic kernel
// sequencer with its output register. Depends on ccr_pkg.
module ccr_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      head_valid_i,
  input  ccr_pkg::item_t            head_i,
  output logic                      pop_o,
  input  ccr_pkg::cfg_t             cfg_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [ccr_pkg::PIX_W-1:0] pixel_out_o,
  output logic                      last_of_run_o,
  output logic                      end_of_line_o
);
  import ccr_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EVAL = 6'b000010,
    S_T3   = 6'b000100,
    S_WGT  = 6'b001000,
    S_MAC  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  localparam logic [FRAC_BITS-1:0]    ZERO_FRAC = '0;
  localparam logic signed [WGT_W-1:0] ONE2 = WGT_W'(2 << FRAC_BITS);
  localparam logic [SUM_W-1:0]        HALF = SUM_W'(1 << FRAC_BITS);

  state_e state_q, state_d;

  logic [PIX_W-1:0]   window_q [4];
  logic [PIX_W-1:0]   window_d [4];
  logic [LEN_W-1:0]   out_cnt_q, out_cnt_d;
  logic [ACC_W-1:0]   phase_q, phase_d;
  logic [BURST_W-1:0] burst_q, burst_d;
  logic [LEN_W-1:0]   c_q, c_d;
  logic               last_q, last_d;
  logic               out_valid_q, out_valid_d;

  // payload pipeline
  logic [FRAC_BITS-1:0]    frac_q, t2_q, t3_q;
  logic [PIX_W-1:0]        tap_q [4];
  logic signed [WGT_W-1:0] w_q [4];
  logic signed [SUM_W-1:0] sum_q;
  logic [PIX_W-1:0]        pixel_out_q;
  logic                    last_of_run_q, end_of_line_q;

  // position decode
  logic [LEN_W-1:0]     n_len, m_len, nm1, base_raw, base_eff, need;
  logic [LEN_W:0]       base_p2;
  logic [FRAC_BITS-1:0] frac_raw, frac_eff;
  logic                 emit_ok, load_out;
  logic signed [IDX_W-1:0] b_s, im1, ip1, ip2;
  logic [1:0]           slot [4];
  logic [2*FRAC_BITS-1:0] sq, cube;
  logic [ACC_W:0]       phase_sum;

  // weights and sum
  logic signed [WGT_W-1:0] f_s, t2_s, t3_s;
  logic signed [WGT_W-1:0] w_d [4];
  logic signed [SUM_W-1:0] acc;
  logic [SUM_W-1:0]        rnd, rshift;
  logic [PIX_W-1:0]        clip;

  function automatic logic [1:0] slot_of(input logic signed [IDX_W-1:0] idx,
                                         input logic [LEN_W-1:0] c);
    logic signed [IDX_W-1:0] s;
    logic [1:0]              r;
    s = idx + IDX_W'(4) - signed'(IDX_W'(c));
    if (s < 0) r = 2'd0;
    else if (s > 3) r = 2'd3;
    else r = s[1:0];
    return r;
  endfunction

  always_comb begin
    n_len    = sat_len(cfg_i.source_length, MIN_SRC);
    m_len    = sat_len(cfg_i.dest_length, MIN_DST);
    nm1      = n_len - LEN_W'(1);
    base_raw = phase_q[ACC_W-1:FRAC_BITS];
    frac_raw = phase_q[FRAC_BITS-1:0];
    if (base_raw >= nm1) begin
      base_eff = nm1;
      frac_eff = (base_raw > nm1) ? ZERO_FRAC : frac_raw;
    end else begin
      base_eff = base_raw;
      frac_eff = frac_raw;
    end
    base_p2 = {1'b0, base_eff} + (LEN_W+1)'(2);
    need    = (base_p2 > {1'b0, nm1}) ? nm1 : base_p2[LEN_W-1:0];
    emit_ok = (out_cnt_q < m_len) && (burst_q < BURST_W'(MAX_RESULTS))
              && (last_q || (need < c_q));

    // tap indexes with the edge substitutions
    b_s = signed'(IDX_W'(base_eff));
    im1 = b_s - IDX_W'(1);
    ip1 = b_s + IDX_W'(1);
    ip2 = b_s + IDX_W'(2);
    if (base_eff == nm1) begin
      im1 = signed'(IDX_W'(nm1)) - IDX_W'(1);
      ip1 = im1;
      ip2 = signed'(IDX_W'(nm1)) - IDX_W'(2);
    end else if (base_eff == nm1 - LEN_W'(1)) begin
      ip2 = b_s;
    end else if (base_eff == '0) begin
      im1 = IDX_W'(1);
    end
    slot[0] = slot_of(im1, c_q);
    slot[1] = slot_of(b_s, c_q);
    slot[2] = slot_of(ip1, c_q);
    slot[3] = slot_of(ip2, c_q);

    sq        = frac_eff * frac_eff;
    cube      = t2_q * frac_q;
    phase_sum = {1'b0, phase_q} + (ACC_W+1)'(cfg_i.step_ratio);
  end

  // doubled Keys weights, a = -0.5
  always_comb begin
    f_s  = signed'(WGT_W'(frac_q));
    t2_s = signed'(WGT_W'(t2_q));
    t3_s = signed'(WGT_W'(t3_q));
    w_d[0] = (t2_s <<< 1) - t3_s - f_s;
    w_d[1] = (t3_s <<< 1) + t3_s - (t2_s <<< 2) - t2_s + ONE2;
    w_d[2] = (t2_s <<< 2) - (t3_s <<< 1) - t3_s + f_s;
    w_d[3] = t3_s - t2_s;
  end

  always_comb begin
    acc = '0;
    for (int k = 0; k < 4; k++) begin
      acc = acc + SUM_W'(signed'({1'b0, tap_q[k]})) * SUM_W'(w_q[k]);
    end
  end

  always_comb begin
    rnd    = unsigned'(sum_q) + HALF;
    rshift = rnd >> (FRAC_BITS + 1);
    if (sum_q < 0) clip = '0;
    else if (rshift > SUM_W'({PIX_W{1'b1}})) clip = '1;
    else clip = rshift[PIX_W-1:0];
  end

  assign load_out = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);
  assign pop_o    = (state_q == S_IDLE) && head_valid_i;

  always_comb begin
    state_d     = state_q;
    window_d    = window_q;
    out_cnt_d   = out_cnt_q;
    phase_d     = phase_q;
    burst_d     = burst_q;
    c_d         = c_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (head_valid_i) begin
          window_d[0] = window_q[1];
          window_d[1] = window_q[2];
          window_d[2] = window_q[3];
          window_d[3] = head_i.pixel;
          c_d         = head_i.count;
          last_d      = head_i.last;
          burst_d     = '0;
          state_d     = S_EVAL;
        end
      end
      S_EVAL: begin
        if (emit_ok) begin
          out_cnt_d = out_cnt_q + LEN_W'(1);
          burst_d   = burst_q + BURST_W'(1);
          phase_d   = phase_sum[ACC_W] ? '1 : phase_sum[ACC_W-1:0];
          state_d   = S_T3;
        end else begin
          if (last_q) begin
            for (int k = 0; k < 4; k++) window_d[k] = '0;
            out_cnt_d = '0;
            phase_d   = '0;
          end
          state_d = S_IDLE;
        end
      end
      S_T3:  state_d = S_WGT;
      S_WGT: state_d = S_MAC;
      S_MAC: state_d = S_OUT;
      S_OUT: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = S_EVAL;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      for (int k = 0; k < 4; k++) window_q[k] <= '0;
      out_cnt_q   <= '0;
      phase_q     <= '0;
      burst_q     <= '0;
      c_q         <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      window_q    <= window_d;
      out_cnt_q   <= out_cnt_d;
      phase_q     <= phase_d;
      burst_q     <= burst_d;
      c_q         <= c_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EVAL && emit_ok) begin
      frac_q <= frac_eff;
      t2_q   <= sq[2*FRAC_BITS-1:FRAC_BITS];
      for (int k = 0; k < 4; k++) tap_q[k] <= window_q[slot[k]];
    end
    if (state_q == S_T3) t3_q <= cube[2*FRAC_BITS-1:FRAC_BITS];
    if (state_q == S_WGT) begin
      for (int k = 0; k < 4; k++) w_q[k] <= w_d[k];
    end
    if (state_q == S_MAC) sum_q <= acc;
    if (load_out) begin
      // registers already hold the advanced position, so emit_ok looks ahead
      pixel_out_q   <= clip;
      last_of_run_q <= !emit_ok;
      end_of_line_q <= (out_cnt_q >= m_len) || (last_q && !emit_ok);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_out_o   = pixel_out_q;
  assign last_of_run_o = last_of_run_q;
  assign end_of_line_o = end_of_line_q;

`ifndef SYNTHESIS
  a_burst_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_q <= BURST_W'(MAX_RESULTS))
    else $error("burst count above limit");

  a_line_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL && !emit_ok && last_q) |=> (out_cnt_q == '0 && phase_q == '0))
    else $error("line state not cleared at line end");

  a_load_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_OUT))
    else $error("result loaded outside output state");

  a_final_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && last_q && !emit_ok) |=> (out_valid_q && last_of_run_q && end_of_line_q))
    else $error("line flush result missing its flags");
`endif

endmodule

FILE: rtl/cubic_convolution_line_resampler_core.sv
// Top level of the cubic convolution line resampler: configuration registers,
// front end, item queue and back end. Depends on ccr_pkg, ccr_front,
// ccr_queue and ccr_back.

// The block takes one 8-bit source pixel per item and produces the pixels of
// a resampled line with the four-tap Keys cubic kernel (a = -0.5), stepping
// by step_ratio (unsigned Q5.16 source pixels per output). A pixel emits every
// output whose taps it completes, up to 24; the pixel that completes the line
// flushes what is still pending, up to the same limit, and clears the line
// state. last_of_run marks the final result of a pixel, end_of_line the final
// result of a line. A pixel that completes no output gives no result. The back
// end works on one pixel at a time and runs each output through a five-step
// sequence (position decode with f*f, f^3, weights, four-tap sum, output
// register). The two-entry queue lets up to two further pixels be taken while
// the back end is busy. Configuration is written through a plain write port
// and must only change while no pixel is in flight.
module cubic_convolution_line_resampler_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_wr_en_i,
  input  logic [ccr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ccr_pkg::STEP_W-1:0]    cfg_data_i,
  // source pixels
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ccr_pkg::PIX_W-1:0]     pixel_in_i,
  // resampled pixels
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ccr_pkg::PIX_W-1:0]     pixel_out_o,
  output logic                          last_of_run_o,
  output logic                          end_of_line_o
);
  import ccr_pkg::*;

  cfg_t  cfg_q, cfg_d;
  item_t push_item, head_item;
  logic  push, q_full, head_valid, pop;

  // register file; writes to unused indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr_en_i) begin
      unique case (cfg_index_i)
        CFG_SOURCE_LENGTH: cfg_d.source_length = cfg_data_i[LEN_W-1:0];
        CFG_DEST_LENGTH:   cfg_d.dest_length   = cfg_data_i[LEN_W-1:0];
        CFG_STEP_RATIO:    cfg_d.step_ratio    = cfg_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_length <= SRC_LEN_RESET;
      cfg_q.dest_length   <= DST_LEN_RESET;
      cfg_q.step_ratio    <= STEP_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front end: count pixels, flag the line end
  ccr_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .pixel_in_i      (pixel_in_i),
    .source_length_i (cfg_q.source_length),
    .q_full_i        (q_full),
    .push_o          (push),
    .push_item_o     (push_item)
  );

  // decouples intake from the output sequencer
  ccr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .item_i       (push_item),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head_item),
    .pop_i        (pop)
  );

  // back end: window, phase and kernel evaluation
  ccr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head_item),
    .pop_o         (pop),
    .cfg_i         (cfg_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_out_o   (pixel_out_o),
    .last_of_run_o (last_of_run_o),
    .end_of_line_o (end_of_line_o)
  );

endmodule
